// File: design/pts_pkg.sv
// ----------------------------------------------------------------------------
// Periodic task slot scheduler package
// Shared sizes, request and status codes, and the record held by each cell.
// ----------------------------------------------------------------------------
package pts_pkg;

  // Number of task slots in the ring.
  localparam int SLOTS = 16;
  // Slot index width, at least one bit.
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  // Width used to compare a slot index against the 4-bit slot field.
  localparam int CMP_W = (IDX_W > 4) ? IDX_W : 4;
  // Most results one dispatch request may produce.
  localparam int BURST = 16;
  localparam int BURST_W = $clog2(BURST + 1);

  typedef enum logic [1:0] {
    REQ_ADD      = 2'd0,
    REQ_DELETE   = 2'd1,
    REQ_TICK     = 2'd2,
    REQ_DISPATCH = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    STS_ADDED     = 3'd0,
    STS_FULL      = 3'd1,
    STS_DELETED   = 3'd2,
    STS_DEL_EMPTY = 3'd3,
    STS_TICK_DONE = 3'd4,
    STS_DUE       = 3'd5,
    STS_NONE      = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } state_t;

  // One task slot as it travels around the ring.
  typedef struct packed {
    logic        used;
    logic [7:0]  handler;
    logic [15:0] delay;
    logic [15:0] period;
    logic [7:0]  runs;
  } slot_t;

  // What the head unit reports about the slot it just handled.
  typedef struct packed {
    logic       take;
    logic [7:0] handler;
    logic [7:0] runs_left;
    logic       removed;
  } head_evt_t;

endpackage

// File: design/pts_cell.sv
// ----------------------------------------------------------------------------
// Slot cell
// Holds one task slot and takes its neighbor's slot on every shift.
// ----------------------------------------------------------------------------
module pts_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           shift,
  input  pts_pkg::slot_t d,
  output pts_pkg::slot_t q
);
  import pts_pkg::*;

  slot_t data;

  always_ff @(posedge clk) begin
    if (rst) begin
      data <= '0;
    end else if (shift) begin
      data <= d;
    end
  end

  assign q = data;

endmodule

// File: design/pts_head.sv
// ----------------------------------------------------------------------------
// Ring head unit
// Applies the current request to the slot passing the head of the ring.
// ----------------------------------------------------------------------------
module pts_head (
  input  pts_pkg::req_t      req,
  input  logic [7:0]         handler_id,
  input  logic [15:0]        start_delay,
  input  logic [15:0]        repeat_period,
  input  logic               sel,
  input  logic               can_add,
  input  logic               can_due,
  input  pts_pkg::slot_t     cur,
  output pts_pkg::slot_t     nxt,
  output pts_pkg::head_evt_t evt
);
  import pts_pkg::*;

  always_comb begin
    nxt = cur;
    evt = '0;
    unique case (req)
      REQ_ADD: begin
        if (can_add && !cur.used) begin
          nxt.used    = 1'b1;
          nxt.handler = handler_id;
          nxt.delay   = start_delay;
          nxt.period  = repeat_period;
          nxt.runs    = 8'd0;
          evt.take    = 1'b1;
        end
      end
      REQ_DELETE: begin
        if (sel) begin
          nxt      = '0;
          evt.take = cur.used;
        end
      end
      REQ_TICK: begin
        if (cur.used) begin
          if (cur.delay == 16'd0) begin
            if (cur.runs != 8'hFF) begin
              nxt.runs = cur.runs + 8'd1;
            end
            if (cur.period != 16'd0) begin
              nxt.delay = cur.period;
            end
          end else begin
            nxt.delay = cur.delay - 16'd1;
          end
        end
      end
      REQ_DISPATCH: begin
        if (can_due && cur.used && cur.runs != 8'd0) begin
          evt.take    = 1'b1;
          evt.handler = cur.handler;
          if (cur.period == 16'd0) begin
            // One-shot task leaves the table, dropping any further runs.
            nxt         = '0;
            evt.removed = 1'b1;
          end else begin
            nxt.runs      = cur.runs - 8'd1;
            evt.runs_left = cur.runs - 8'd1;
          end
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

// File: design/periodic_task_slot_scheduler.sv
// ----------------------------------------------------------------------------
// Periodic task slot scheduler
// Time-triggered cooperative scheduler built as a rotating ring of slot cells.
// ----------------------------------------------------------------------------
// A request is accepted on a rising clock edge where start is high and busy
// is low. The request fields (req_type, slot, handler_id, start_delay,
// repeat_period) are captured at that edge and busy stays high until the
// request is finished. Each result appears on the result ports for exactly
// one cycle, marked by result_valid; the receiver must take it then, since
// there is no way to hold results off. The last flag marks the final result
// of a request.
// The task table lives in a ring of SLOTS cells. Every request makes one full
// turn of the ring, SLOTS shifts, so each slot passes the head unit once in
// ascending order and ends up back where it started. A request keeps busy
// high through the turn and until its final result is posted, and a new
// request is accepted only once busy is low again. Add, delete and tick
// requests give a single result at the end of the turn. A dispatch request
// gives one result per due slot, each posted when the next due slot is found,
// the final one at the end of the turn; with no due slot it gives a single
// none result. Reset empties the table and returns the block to idle.
// ----------------------------------------------------------------------------
module periodic_task_slot_scheduler (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [3:0]  slot,
  input  logic [7:0]  handler_id,
  input  logic [15:0] start_delay,
  input  logic [15:0] repeat_period,
  output logic        result_valid,
  output logic [2:0]  status,
  output logic [3:0]  slot_out,
  output logic [7:0]  handler_out,
  output logic [7:0]  runs_left,
  output logic        removed,
  output logic        last
);
  import pts_pkg::*;

  // Control state.
  state_t             state, state_next;
  logic [IDX_W-1:0]   idx, idx_next;
  logic [BURST_W-1:0] burst, burst_next;

  // The request being worked on, captured when it is accepted.
  req_t        cur_req;
  logic [3:0]  cur_slot;
  logic [7:0]  cur_handler;
  logic [15:0] cur_delay;
  logic [15:0] cur_period;

  // Held result: the slot added or deleted, or the latest due slot of a
  // dispatch that is waiting to learn whether it is the final one.
  logic       hit, hit_next;
  logic [3:0] hit_slot, hit_slot_next;
  logic [7:0] hit_handler, hit_handler_next;
  logic [7:0] hit_runs, hit_runs_next;
  logic       hit_removed, hit_removed_next;

  // Result register.
  logic       result_valid_next;
  logic [2:0] status_reg, status_next;
  logic [3:0] slot_reg, slot_next;
  logic [7:0] handler_reg, handler_next;
  logic [7:0] runs_reg, runs_next;
  logic       removed_reg, removed_next;
  logic       last_reg, last_next;

  // Ring of cells.
  slot_t     cell_q [SLOTS];
  slot_t     head_nxt;
  head_evt_t evt;
  logic      shift;
  logic      sel;

  assign shift = (state == ST_RUN);
  assign sel   = (CMP_W'(idx) == CMP_W'(cur_slot));

  // Cell 0 always holds the slot at the head; the head unit's output enters
  // the far end of the ring so that every slot is home after one full turn.
  for (genvar k = 0; k < SLOTS; k++) begin : g_ring
    slot_t d;
    if (k == SLOTS - 1) begin : g_tail
      assign d = head_nxt;
    end else begin : g_mid
      assign d = cell_q[k+1];
    end
    pts_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (shift),
      .d     (d),
      .q     (cell_q[k])
    );
  end

  pts_head u_head (
    .req           (cur_req),
    .handler_id    (cur_handler),
    .start_delay   (cur_delay),
    .repeat_period (cur_period),
    .sel           (sel),
    .can_add       (!hit),
    .can_due       (burst < BURST_W'(BURST)),
    .cur           (cell_q[0]),
    .nxt           (head_nxt),
    .evt           (evt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      idx          <= '0;
      burst        <= '0;
      hit          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      idx          <= idx_next;
      burst        <= burst_next;
      hit          <= hit_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      cur_req     <= req_t'(req_type);
      cur_slot    <= slot;
      cur_handler <= handler_id;
      cur_delay   <= start_delay;
      cur_period  <= repeat_period;
    end
    hit_slot    <= hit_slot_next;
    hit_handler <= hit_handler_next;
    hit_runs    <= hit_runs_next;
    hit_removed <= hit_removed_next;
    status_reg  <= status_next;
    slot_reg    <= slot_next;
    handler_reg <= handler_next;
    runs_reg    <= runs_next;
    removed_reg <= removed_next;
    last_reg    <= last_next;
  end

  always_comb begin
    state_next        = state;
    idx_next          = idx;
    burst_next        = burst;
    hit_next          = hit;
    hit_slot_next     = hit_slot;
    hit_handler_next  = hit_handler;
    hit_runs_next     = hit_runs;
    hit_removed_next  = hit_removed;
    result_valid_next = 1'b0;
    status_next       = status_reg;
    slot_next         = slot_reg;
    handler_next      = handler_reg;
    runs_next         = runs_reg;
    removed_next      = removed_reg;
    last_next         = last_reg;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_RUN;
          idx_next   = '0;
          burst_next = '0;
          hit_next   = 1'b0;
        end
      end
      ST_RUN: begin
        if (evt.take) begin
          if (cur_req == REQ_DISPATCH && hit) begin
            // A later due slot exists, so the held one is not the final result.
            result_valid_next = 1'b1;
            status_next       = STS_DUE;
            slot_next         = hit_slot;
            handler_next      = hit_handler;
            runs_next         = hit_runs;
            removed_next      = hit_removed;
            last_next         = 1'b0;
          end
          hit_next         = 1'b1;
          hit_slot_next    = 4'(idx);
          hit_handler_next = evt.handler;
          hit_runs_next    = evt.runs_left;
          hit_removed_next = evt.removed;
          burst_next       = burst + BURST_W'(1);
        end
        if (idx == IDX_W'(SLOTS - 1)) begin
          state_next = ST_FIN;
        end else begin
          idx_next = idx + IDX_W'(1);
        end
      end
      ST_FIN: begin
        result_valid_next = 1'b1;
        last_next         = 1'b1;
        slot_next         = 4'd0;
        handler_next      = 8'd0;
        runs_next         = 8'd0;
        removed_next      = 1'b0;
        unique case (cur_req)
          REQ_ADD: begin
            status_next = hit ? STS_ADDED : STS_FULL;
            slot_next   = hit ? hit_slot : 4'd0;
          end
          REQ_DELETE: begin
            status_next = hit ? STS_DELETED : STS_DEL_EMPTY;
            slot_next   = cur_slot;
          end
          REQ_TICK: begin
            status_next = STS_TICK_DONE;
          end
          REQ_DISPATCH: begin
            if (hit) begin
              status_next  = STS_DUE;
              slot_next    = hit_slot;
              handler_next = hit_handler;
              runs_next    = hit_runs;
              removed_next = hit_removed;
            end else begin
              status_next = STS_NONE;
            end
          end
          default: begin
            status_next = STS_NONE;
          end
        endcase
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy        = (state != ST_IDLE);
  assign status      = status_reg;
  assign slot_out    = slot_reg;
  assign handler_out = handler_reg;
  assign runs_left   = runs_reg;
  assign removed     = removed_reg;
  assign last        = last_reg;

endmodule
